// ===== src/ctbm_pkg.sv =====
// Shared constants and types for the CPU time budget monitor.
// Used by the controller, the datapath and the top level; depends on nothing.
package ctbm_pkg;

	// Accumulator sets and derived widths.
	localparam int NUM_SETS  = 8;
	localparam int SET_W     = $clog2(NUM_SETS);
	localparam int RATE_W    = 14;
	localparam int WORD_W    = 64;
	localparam int PROD_W    = WORD_W + 1 + RATE_W;

	// Iteration counts of the shift-add multiplier and the restoring divider.
	localparam int MUL_STEPS = RATE_W;
	localparam int DIV_STEPS = WORD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Reset value of the tick rate register.
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(100);

	// Command codes.
	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_SET  = 2'd1;
	localparam logic [1:0] CMD_TEST = 2'd2;

	// Register selects (paddr bit 2 picks the 32-bit register).
	localparam logic REG_MULTI = 1'b0;
	localparam logic REG_RATE  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             add;
		logic             sum_clr;
		logic             sum_step;
		logic             mul_step;
		logic             ticks;
		logic             budget;
		logic             thr_step;
		logic             div_init;
		logic             div_step;
		logic             cmp;
		logic             out_load;
		logic [SET_W-1:0] idx;
	} dp_cmd_t;

endpackage

// ===== src/ctbm_ctrl.sv =====
// Sequencing state machine of the CPU time budget monitor.
// Depends on ctbm_pkg; drives the datapath through a dp_cmd_t bundle.
module ctbm_ctrl import ctbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       multi,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	output logic       out_valid,
	input  logic       out_stall,
	output dp_cmd_t    cmd
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_ADD    = 10'b0000000010,
		S_SUM    = 10'b0000000100,
		S_MUL    = 10'b0000001000,
		S_TICKS  = 10'b0000010000,
		S_BUDGET = 10'b0000100000,
		S_THR    = 10'b0001000000,
		S_DIV    = 10'b0010000000,
		S_CMP    = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         cmd_q;
	logic               out_valid_q;
	logic               walk_last;

	// The last set of a walk depends on how many sets are active.
	assign walk_last = (cnt_q == (multi ? CNT_W'(NUM_SETS - 1) : '0));
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.idx = cnt_q[SET_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.sum_clr = 1'b1;
					state_d     = (command == CMD_ADD) ? S_ADD : S_SUM;
				end
			end
			S_ADD: begin
				cmd.add     = 1'b1;
				cmd.sum_clr = 1'b1;
				state_d     = S_SUM;
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (walk_last) begin
					state_d = (cmd_q == CMD_SET || cmd_q == CMD_TEST) ? S_MUL : S_OUT;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					state_d = S_TICKS;
				end
			end
			S_TICKS: begin
				cmd.ticks = 1'b1;
				state_d   = S_BUDGET;
			end
			S_BUDGET: begin
				cmd.budget   = 1'b1;
				cmd.div_init = 1'b1;
				state_d      = S_THR;
			end
			S_THR: begin
				cmd.thr_step = 1'b1;
				if (walk_last) begin
					state_d = (cmd_q == CMD_TEST) ? S_DIV : S_OUT;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cmd_q       <= CMD_ADD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.load) begin
				cmd_q <= command;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/ctbm_dp.sv =====
// Datapath of the CPU time budget monitor: accumulators, thresholds,
// multiplier, divider and result register. Depends on ctbm_pkg.
module ctbm_dp import ctbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic              multi,
	input  logic [RATE_W-1:0] rate,
	input  logic [2:0]        set_index,
	input  logic [WORD_W-1:0] delta_ticks,
	input  logic [WORD_W-1:0] limit_seconds,
	input  logic [WORD_W-1:0] increment_seconds,
	output logic              crossed,
	output logic [WORD_W-1:0] total_ticks
);

	logic [WORD_W-1:0] acc_q [NUM_SETS];
	logic [WORD_W-1:0] thr_q [NUM_SETS];

	logic [2:0]        set_q;
	logic [WORD_W-1:0] delta_q, limit_q, incr_q;
	logic [WORD_W-1:0] sum_q, ticks_q, budget_q, quo_q;
	logic [PROD_W-1:0] mcand_q, prod_q;
	logic [RATE_W-1:0] mplr_q, rem_q;
	logic              inf_q, crossed_q;
	logic              out_crossed_q;
	logic [WORD_W-1:0] out_total_q;

	logic [RATE_W-1:0] rate_eff;
	logic [2:0]        set_eff;
	logic              set_ok;
	logic [SET_W-1:0]  rd_idx;
	logic [WORD_W-1:0] acc_rd, acc_new;
	logic [WORD_W:0]   ssum, tsum, diff, csum;
	logic [WORD_W-1:0] budget_d;
	logic [RATE_W:0]   rs;
	logic              q_bit;

	// A zero rate counts as one tick per second.
	assign rate_eff = (rate == '0) ? RATE_W'(1) : rate;
	assign set_eff  = multi ? set_q : 3'd0;
	assign set_ok   = (int'(set_eff) < NUM_SETS);
	assign rd_idx   = cmd.add ? set_eff[SET_W-1:0] : cmd.idx;
	assign acc_rd   = acc_q[rd_idx];
	assign acc_new  = acc_rd + delta_q;

	assign ssum = {1'b0, sum_q} + {1'b0, acc_rd};
	assign tsum = {1'b0, acc_rd} + {1'b0, budget_q};
	assign diff = {1'b0, ticks_q} - {1'b0, sum_q};
	assign csum = {1'b0, quo_q} + {1'b0, incr_q};

	always_comb begin
		if (inf_q) begin
			budget_d = '1;
		end else if (diff[WORD_W]) begin
			budget_d = '0;
		end else if (multi) begin
			budget_d = diff[WORD_W-1:0] / NUM_SETS;
		end else begin
			budget_d = diff[WORD_W-1:0];
		end
	end

	// Restoring division step; the remainder always stays below the rate.
	assign rs    = {rem_q, quo_q[WORD_W-1]};
	assign q_bit = (rs >= {1'b0, rate_eff});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SETS; i++) begin
				acc_q[i] <= '0;
				thr_q[i] <= '1;
			end
		end else begin
			if (cmd.add && set_ok) begin
				acc_q[set_eff[SET_W-1:0]] <= acc_new;
			end
			if (cmd.thr_step) begin
				thr_q[cmd.idx] <= tsum[WORD_W] ? '1 : tsum[WORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			set_q     <= set_index;
			delta_q   <= delta_ticks;
			limit_q   <= limit_seconds;
			incr_q    <= increment_seconds;
			mcand_q   <= PROD_W'({1'b0, limit_seconds} + 65'd1);
			mplr_q    <= rate_eff;
			prod_q    <= '0;
			crossed_q <= 1'b0;
		end
		if (cmd.add && set_ok) begin
			crossed_q <= (acc_new >= thr_q[set_eff[SET_W-1:0]]);
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_step) begin
			sum_q <= ssum[WORD_W] ? '1 : ssum[WORD_W-1:0];
		end
		if (cmd.mul_step) begin
			if (mplr_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
			mplr_q  <= {1'b0, mplr_q[RATE_W-1:1]};
		end
		// prod holds (limit + 1) * rate: at or above 2^64 means no finite budget.
		if (cmd.ticks) begin
			inf_q   <= |prod_q[PROD_W-1:WORD_W];
			ticks_q <= prod_q[WORD_W-1:0] - WORD_W'(rate_eff);
		end
		if (cmd.budget) begin
			budget_q <= budget_d;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= sum_q;
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? RATE_W'(rs - {1'b0, rate_eff}) : rs[RATE_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], q_bit};
		end
		if (cmd.cmp) begin
			crossed_q <= csum[WORD_W] | (csum[WORD_W-1:0] >= limit_q);
		end
		if (cmd.out_load) begin
			out_crossed_q <= crossed_q;
			out_total_q   <= sum_q;
		end
	end

	assign crossed     = out_crossed_q;
	assign total_ticks = out_total_q;

endmodule

// ===== src/cpu_time_budget_monitor_unit.sv =====
// Top level of the CPU time budget monitor: configuration registers and
// the controller and datapath. Depends on ctbm_pkg, ctbm_ctrl and ctbm_dp.

// The monitor keeps eight 64-bit tick accumulators, each with a threshold,
// and handles one input word at a time. An add word charges the set and
// compares it with its threshold, then walks the N active sets (8 in
// multi-set mode, 1 otherwise) to form the saturating total. A set-limit
// word walks the total, runs a shift-add multiplier that forms (limit + 1)
// times the tick rate, forms the budget, and then walks again to move every
// active threshold. A test-limit word also runs a bit-serial restoring
// divider that turns the total into whole seconds, then compares them,
// plus the increment, with the limit. An unused command code only walks
// the total. The result sits in an output register, so a new word is
// accepted while an earlier result still waits to be taken.
// Registers on the APB port: multi_set_mode at byte address 0 (bit 0), and
// ticks_per_second at byte address 4 (bits 13:0, a value of 0 acts as 1).
// Only paddr bit 2 selects the register, and both read back as written.
module cpu_time_budget_monitor_unit import ctbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// Input words.
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [2:0]        set_index,
	input  logic [WORD_W-1:0] delta_ticks,
	input  logic [WORD_W-1:0] limit_seconds,
	input  logic [WORD_W-1:0] increment_seconds,
	// Result words.
	output logic              out_valid,
	input  logic              out_stall,
	output logic              crossed,
	output logic [WORD_W-1:0] total_ticks
);

	logic              multi_q;
	logic [RATE_W-1:0] rate_q;
	logic              wr_en;
	dp_cmd_t           cmd;

	// Writes land in the access phase; the port never inserts wait states.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_q <= 1'b0;
			rate_q  <= RATE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MULTI: multi_q <= pwdata[0];
				REG_RATE:  rate_q  <= pwdata[RATE_W-1:0];
				default:   multi_q <= multi_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MULTI: prdata = {31'd0, multi_q};
			REG_RATE:  prdata = {{(32 - RATE_W){1'b0}}, rate_q};
			default:   prdata = '0;
		endcase
	end

	// The controller sequences each word; the datapath does the arithmetic.
	ctbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.multi     (multi_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ctbm_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.multi             (multi_q),
		.rate              (rate_q),
		.set_index         (set_index),
		.delta_ticks       (delta_ticks),
		.limit_seconds     (limit_seconds),
		.increment_seconds (increment_seconds),
		.crossed           (crossed),
		.total_ticks       (total_ticks)
	);

endmodule

// ===== tb/cpu_time_budget_monitor_unit_tb.sv =====
// Self-checking testbench for the CPU time budget monitor top level.
// Depends on ctbm_pkg and cpu_time_budget_monitor_unit; drives random and
// directed words, predicts each result and compares it field by field.
`timescale 1ns / 100ps

module cpu_time_budget_monitor_unit_tb;
	import ctbm_pkg::*;

	// Command code 3 has no meaning in the block; it only reports the total.
	localparam logic [1:0]        CMD_UNUSED = 2'd3;
	localparam logic [WORD_W-1:0] TICKS_MAX  = '1;
	// Watchdog: far beyond the slowest legal run of about 1050 words.
	localparam int                WATCHDOG_NS = 8_000_000;

	// One input word as the sender presents it.
	typedef struct {
		logic [1:0]        command;
		logic [2:0]        set_index;
		logic [WORD_W-1:0] delta;
		logic [WORD_W-1:0] limit;
		logic [WORD_W-1:0] incr;
	} monitor_cmd_t;

	// One result word as the block should report it.
	typedef struct {
		logic              crossed;
		logic [WORD_W-1:0] total;
	} budget_report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        command = '0;
	logic [2:0]        set_index = '0;
	logic [WORD_W-1:0] delta_ticks = '0;
	logic [WORD_W-1:0] limit_seconds = '0;
	logic [WORD_W-1:0] increment_seconds = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              crossed;
	logic [WORD_W-1:0] total_ticks;

	cpu_time_budget_monitor_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.set_index         (set_index),
		.delta_ticks       (delta_ticks),
		.limit_seconds     (limit_seconds),
		.increment_seconds (increment_seconds),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.crossed           (crossed),
		.total_ticks       (total_ticks)
	);

	// 8 ns clock period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Words waiting to be offered, and reports waiting to come back.
	monitor_cmd_t   pending_words[$];
	budget_report_t expected_reports[$];

	// When set, neither side idles; used for one long stretch of the run.
	logic steady = 1'b0;

	int unsigned words_accepted = 0;
	int unsigned reports_checked = 0;
	int unsigned crossings_seen = 0;
	int unsigned mismatches = 0;

	// Our own copy of the monitor: the configuration and both tick stores.
	logic              multi_model = 1'b0;
	logic [RATE_W-1:0] rate_model = RATE_RESET;
	logic [WORD_W-1:0] acc_model [NUM_SETS];
	logic [WORD_W-1:0] thr_model [NUM_SETS];

	initial begin
		for (int i = 0; i < NUM_SETS; i++) begin
			acc_model[i] = '0;
			thr_model[i] = TICKS_MAX;
		end
	end

	// A tick rate of zero behaves as one tick per second.
	function automatic logic [WORD_W-1:0] tick_rate();
		return (rate_model == '0) ? WORD_W'(1) : WORD_W'(rate_model);
	endfunction

	// Saturating sum over the active sets: all eight in multi-set mode,
	// only set zero otherwise.
	function automatic logic [WORD_W-1:0] active_total();
		logic [WORD_W:0] sum;
		int              n;
		n = multi_model ? NUM_SETS : 1;
		sum = '0;
		for (int i = 0; i < n; i++) begin
			sum = {1'b0, sum[WORD_W-1:0]} + {1'b0, acc_model[i]};
			if (sum[WORD_W])
				return TICKS_MAX;
		end
		return sum[WORD_W-1:0];
	endfunction

	// Turns a limit in seconds into a remaining tick budget and moves the
	// threshold of each active set to its accumulator plus that budget.
	// Limits that cannot be expressed in 64 bits of ticks give no limit.
	function automatic void shift_thresholds(logic [WORD_W-1:0] limit,
			logic [WORD_W-1:0] total);
		logic [WORD_W-1:0] rate;
		logic [WORD_W-1:0] ticks;
		logic [WORD_W-1:0] budget;
		logic [WORD_W:0]   sum;
		int                n;
		rate = tick_rate();
		n = multi_model ? NUM_SETS : 1;
		if (limit >= TICKS_MAX / rate) begin
			budget = TICKS_MAX;
		end else begin
			ticks = limit * rate;
			budget = (total >= ticks) ? '0 : ticks - total;
			if (multi_model)
				budget = budget / NUM_SETS;
		end
		for (int i = 0; i < n; i++) begin
			sum = {1'b0, acc_model[i]} + {1'b0, budget};
			thr_model[i] = sum[WORD_W] ? TICKS_MAX : sum[WORD_W-1:0];
		end
	endfunction

	// Applies one accepted word to the model and returns the report it causes.
	function automatic budget_report_t apply_word(monitor_cmd_t w);
		budget_report_t    r;
		logic [WORD_W-1:0] total;
		logic [WORD_W-1:0] secs;
		logic [WORD_W:0]   sum;
		int                s;
		r.crossed = 1'b0;
		case (w.command)
			CMD_ADD: begin
				// Single-set mode charges set zero whatever the index says.
				s = multi_model ? int'(w.set_index) : 0;
				acc_model[s] = acc_model[s] + w.delta;
				r.crossed = (acc_model[s] >= thr_model[s]);
			end
			CMD_SET: begin
				shift_thresholds(w.limit, active_total());
			end
			CMD_TEST: begin
				total = active_total();
				secs = total / tick_rate();
				sum = {1'b0, secs} + {1'b0, w.incr};
				shift_thresholds(w.limit, total);
				// A sum that overflows 64 bits always counts as reaching the limit.
				r.crossed = sum[WORD_W] || (sum[WORD_W-1:0] >= w.limit);
			end
			default: ;
		endcase
		r.total = active_total();
		return r;
	endfunction

	function automatic monitor_cmd_t word_of(logic [1:0] cmd, logic [2:0] idx,
			logic [WORD_W-1:0] delta, logic [WORD_W-1:0] limit,
			logic [WORD_W-1:0] incr);
		monitor_cmd_t w;
		w.command = cmd;
		w.set_index = idx;
		w.delta = delta;
		w.limit = limit;
		w.incr = incr;
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] any_ticks();
		return {$urandom, $urandom};
	endfunction

	// Random word shaped to stay near the interesting region: deltas of a few
	// seconds, and limits mostly just above the time already used, so that
	// thresholds land within reach and get crossed. The rest is wide noise
	// and limits at the edge where the budget turns infinite.
	function automatic monitor_cmd_t random_word();
		monitor_cmd_t      w;
		int unsigned       pick;
		logic [WORD_W-1:0] rate;
		rate = tick_rate();
		pick = $urandom_range(0, 99);
		if (pick < 55)
			w.command = CMD_ADD;
		else if (pick < 72)
			w.command = CMD_SET;
		else if (pick < 95)
			w.command = CMD_TEST;
		else
			w.command = CMD_UNUSED;
		w.set_index = 3'($urandom_range(0, 7));

		pick = $urandom_range(0, 99);
		if (pick < 85)
			w.delta = WORD_W'($urandom_range(0, 3 * rate[31:0]));
		else if (pick < 95)
			w.delta = any_ticks();
		else
			w.delta = pick[0] ? TICKS_MAX : '0;

		pick = $urandom_range(0, 99);
		if (pick < 70)
			w.limit = active_total() / rate + WORD_W'($urandom_range(0, 20));
		else if (pick < 80)
			w.limit = TICKS_MAX / rate + WORD_W'($urandom_range(0, 4)) - WORD_W'(2);
		else if (pick < 90)
			w.limit = any_ticks();
		else
			w.limit = WORD_W'($urandom_range(0, 5));

		pick = $urandom_range(0, 99);
		if (pick < 80)
			w.incr = WORD_W'($urandom_range(0, 10));
		else if (pick < 90)
			w.incr = any_ticks();
		else
			w.incr = TICKS_MAX;
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s expected 0x%h, got 0x%h", $realtime, what, want,
				got);
	endtask

	// Sender. A word stays on the port until it is taken; then the next one
	// from the pending queue is offered, unless this cycle idles. The model
	// is advanced at the very edge that takes the word, so the expectation
	// always matches the order in which the block sees its words.
	always @(posedge clk or negedge arst_n) begin : sender
		monitor_cmd_t nxt;
		logic         offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_reports.push_back(apply_word(word_of(command, set_index,
					delta_ticks, limit_seconds, increment_seconds)));
				words_accepted++;
			end
			if (!in_valid || !in_stall) begin
				offer = 1'b0;
				if (pending_words.size() > 0 && (steady || $urandom_range(0, 99) >= 25)) begin
					nxt = pending_words.pop_front();
					offer = 1'b1;
				end
				in_valid <= offer;
				if (offer) begin
					command <= nxt.command;
					set_index <= nxt.set_index;
					delta_ticks <= nxt.delta;
					limit_seconds <= nxt.limit;
					increment_seconds <= nxt.incr;
				end
			end
		end
	end

	// Receiver. Stalls about a quarter of the cycles outside the steady
	// stretch, and checks every result word it takes against the oldest
	// expectation.
	always @(posedge clk or negedge arst_n) begin : receiver
		budget_report_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: result word with nothing expected",
							$realtime);
				end else begin
					want = expected_reports.pop_front();
					reports_checked++;
					if (crossed)
						crossings_seen++;
					if (crossed !== want.crossed)
						report_mismatch("crossed", WORD_W'(want.crossed), WORD_W'(crossed));
					if (total_ticks !== want.total)
						report_mismatch("total_ticks", want.total, total_ticks);
				end
			end
			out_stall <= !steady && ($urandom_range(0, 99) < 25);
		end
	end

	// One APB transfer: a setup phase, then an access phase that completes
	// on the edge where pready is high.
	task automatic apb_cycle(logic wr, logic sel, logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {sel, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reads a register and checks it against the model's copy.
	task automatic check_register(logic sel);
		logic [31:0] got;
		apb_cycle(1'b0, sel, '0, got);
		if (sel == REG_MULTI) begin
			if (got[0] !== multi_model)
				report_mismatch("multi_set_mode readback", WORD_W'(multi_model),
					WORD_W'(got[0]));
		end else if (got[RATE_W-1:0] !== rate_model) begin
			report_mismatch("ticks_per_second readback", WORD_W'(rate_model),
				WORD_W'(got[RATE_W-1:0]));
		end
	endtask

	// Writes a register, mirrors it in the model and reads it back. Only
	// called while the block has nothing in flight.
	task automatic program_register(logic sel, logic [31:0] value);
		logic [31:0] unused;
		apb_cycle(1'b1, sel, value, unused);
		if (sel == REG_MULTI)
			multi_model = value[0];
		else
			rate_model = value[RATE_W-1:0];
		check_register(sel);
		@(negedge clk);
	endtask

	// Waits until every queued word is taken and every report has come
	// back. Sampling on the falling edge keeps this clear of the updates
	// made at the rising edge.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// Keeps at most two words queued, so that each random word is shaped
	// from a model state only a word or two behind the block.
	task automatic feed_random(int count);
		repeat (count) begin
			do
				@(negedge clk);
			while (pending_words.size() >= 2);
			pending_words.push_back(random_word());
		end
	endtask

	initial begin : stimulus
		int unsigned rate_pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Both registers must come out of reset with their documented values.
		check_register(REG_MULTI);
		check_register(REG_RATE);
		@(negedge clk);

		// Single-set mode at the reset rate of 100 ticks per second. The add
		// with index 3 must still charge set zero. A limit of 5 s leaves 250
		// ticks, so 249 more stays below and one more reaches the threshold.
		pending_words.push_back(word_of(CMD_TEST, 3'd0, '0, '0, '0));
		pending_words.push_back(word_of(CMD_ADD, 3'd3, 64'd250, '0, '0));
		pending_words.push_back(word_of(CMD_SET, 3'd0, '0, 64'd5, '0));
		pending_words.push_back(word_of(CMD_ADD, 3'd7, 64'd249, '0, '0));
		pending_words.push_back(word_of(CMD_ADD, 3'd0, 64'd1, '0, '0));
		pending_words.push_back(word_of(CMD_UNUSED, 3'd7, TICKS_MAX, TICKS_MAX,
			TICKS_MAX));
		// A limit already behind the time used floors the budget at zero.
		pending_words.push_back(word_of(CMD_TEST, 3'd0, '0, 64'd4, '0));
		// Exactly at, then just below, the limit where the budget goes infinite.
		pending_words.push_back(word_of(CMD_SET, 3'd0, '0, TICKS_MAX / 100, '0));
		pending_words.push_back(word_of(CMD_SET, 3'd0, '0, TICKS_MAX / 100 - 1, '0));
		// Seconds plus increment overflowing 64 bits counts as reaching the limit.
		pending_words.push_back(word_of(CMD_TEST, 3'd0, '0, 64'd10, TICKS_MAX));
		// An all-ones delta wraps the accumulator.
		pending_words.push_back(word_of(CMD_ADD, 3'd0, TICKS_MAX, '0, '0));
		drain();

		// Multi-set mode at 10000 ticks per second: drive the total into saturation, so
		// a set limit leaves no budget and every threshold equals its set.
		program_register(REG_MULTI, 32'd1);
		program_register(REG_RATE, 32'd10000);
		pending_words.push_back(word_of(CMD_ADD, 3'd0, 64'hFFFF_FFFF_FFFF_FFF0, '0, '0));
		pending_words.push_back(word_of(CMD_ADD, 3'd7, 64'hFFFF_FFFF_FFFF_FFF0, '0, '0));
		pending_words.push_back(word_of(CMD_SET, 3'd0, '0, 64'd3, '0));
		pending_words.push_back(word_of(CMD_ADD, 3'd1, '0, '0, '0));
		pending_words.push_back(word_of(CMD_TEST, 3'd0, '0, TICKS_MAX, '0));
		pending_words.push_back(word_of(CMD_ADD, 3'd7, 64'd1, '0, '0));
		drain();

		// A zero rate must act as one tick per second; then the widest
		// value the register holds.
		program_register(REG_RATE, 32'd0);
		pending_words.push_back(word_of(CMD_SET, 3'd2, '0, 64'd100, '0));
		pending_words.push_back(word_of(CMD_TEST, 3'd0, '0, TICKS_MAX - 1, 64'd1));
		drain();
		program_register(REG_RATE, 32'h0000_3FFF);
		pending_words.push_back(word_of(CMD_TEST, 3'd0, '0, 64'd1, '0));
		pending_words.push_back(word_of(CMD_ADD, 3'd6, 64'h8000_0000_0000_0000, '0, '0));
		drain();

		// Random phases, each under its own configuration. The second one
		// runs with no idling on either side.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: rate_pick = 100;
				1: rate_pick = 10000;
				2: rate_pick = 1;
				3: rate_pick = $urandom_range(1, 10000);
				default: rate_pick = $urandom_range(2, 50);
			endcase
			program_register(REG_MULTI, (phase == 0 || phase == 3) ? 32'd0 : 32'd1);
			program_register(REG_RATE, rate_pick);
			steady = (phase == 1);
			feed_random((phase == 1) ? 250 : (phase == 3) ? 150 : 200);
			drain();
			steady = 1'b0;
		end

		// Room for any stray result word to show up after the last one.
		repeat (100) @(negedge clk);

		$display("summary: %0d words taken, %0d results checked, %0d with crossed set",
			words_accepted, reports_checked, crossings_seen);
		$display("summary: single and multi-set modes, tick rates 0 to 16383, %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("timeout: %0d words taken, %0d results checked", words_accepted,
			reports_checked);
		$display("status: fail");
		$finish;
	end

endmodule
